// File: hw/rtl/corner_state_coordinate_codec_top_defines.svh
// Assertion helpers for the corner state coordinate codec.
// Each macro expects clk and rst_n in scope.
`ifndef CORNER_STATE_COORDINATE_CODEC_TOP_DEFINES_SVH
`define CORNER_STATE_COORDINATE_CODEC_TOP_DEFINES_SVH

// Same-cycle implication.
`define CSC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csc same-cycle check failed");

// Next-cycle implication.
`define CSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csc next-cycle check failed");

`endif

// File: hw/rtl/csc_pkg.sv
package csc_pkg;

  localparam int unsigned ELEMS       = 8;
  localparam int unsigned ELEM_W      = 3;
  localparam int unsigned TW_W        = 2;
  localparam int unsigned TW_DIGITS   = 7;
  localparam int unsigned IDX_W       = 27;
  localparam int unsigned PERM_W      = ELEMS * ELEM_W;
  localparam int unsigned TWIST_W     = ELEMS * TW_W;
  localparam int unsigned TWIST_SPACE = 2187;
  localparam int unsigned PERM_SPACE  = 40320;
  localparam int unsigned STATE_SPACE = PERM_SPACE * TWIST_SPACE;
  localparam int unsigned CELLS       = ELEMS + TW_DIGITS;

  localparam int unsigned FACT [0:8] = '{1, 1, 2, 6, 24, 120, 720, 5040, 40320};
  // weight of twist digit i, twist 0 most significant
  localparam int unsigned TW_WEIGHT [0:6] = '{729, 243, 81, 27, 9, 3, 1};

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } csc_op_t;

  // item as it travels down the cell chain
  typedef struct packed {
    csc_op_t                        op;
    logic                           oor;
    logic [PERM_W-1:0]              perm_word;
    logic [TWIST_W-1:0]             twist_word;
    logic [IDX_W-1:0]               acc;
    logic [ELEMS-1:0][ELEM_W-1:0]   avail;
    logic [PERM_W-1:0]              perm_acc;
    logic [TW_DIGITS*TW_W-1:0]      twist_acc;
    logic [1:0]                     tsum;
  } csc_item_t;

  typedef struct packed {
    csc_op_t            op;
    logic               bad;
    logic [IDX_W-1:0]   index;
    logic [PERM_W-1:0]  perm;
    logic [TWIST_W-1:0] twist;
  } csc_result_t;

endpackage

// File: hw/rtl/csc_perm_cell.sv
module csc_perm_cell
  import csc_pkg::*;
#(
  parameter int unsigned POS = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      i_vld,
  input  csc_item_t i_item,
  output logic      o_vld,
  output csc_item_t o_item
);

  localparam int unsigned RADIX = ELEMS - POS;
  localparam logic [IDX_W-1:0] WEIGHT = IDX_W'(FACT[ELEMS-1-POS] * TWIST_SPACE);

  logic                vld_r;
  csc_item_t           item_r;
  csc_item_t           item_nxt;
  logic [ELEM_W-1:0]   elem;
  logic [ELEM_W-1:0]   less;
  logic [ELEM_W-1:0]   digit;

  always_comb begin
    item_nxt = i_item;
    elem     = i_item.perm_word[ELEM_W*POS +: ELEM_W];
    less     = '0;
    for (int j = POS + 1; j < ELEMS; j++) begin
      if (i_item.perm_word[ELEM_W*j +: ELEM_W] < elem) begin
        less = less + ELEM_W'(1);
      end
    end
    // factorial digit: count thresholds reached
    digit = '0;
    for (int k = 1; k < RADIX; k++) begin
      if (i_item.acc >= IDX_W'(k * FACT[ELEMS-1-POS] * TWIST_SPACE)) begin
        digit = digit + ELEM_W'(1);
      end
    end
    unique case (i_item.op)
      OP_ENCODE: begin
        item_nxt.acc = i_item.acc + IDX_W'(less) * WEIGHT;
      end
      OP_DECODE: begin
        item_nxt.acc = i_item.acc - IDX_W'(digit) * WEIGHT;
        item_nxt.perm_acc[ELEM_W*POS +: ELEM_W] = i_item.avail[digit];
        // drop the picked element from the list
        for (int j = 0; j < ELEMS - 1; j++) begin
          if (ELEM_W'(j) >= digit) begin
            item_nxt.avail[j] = i_item.avail[j+1];
          end
        end
      end
      default: item_nxt = i_item;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign o_vld  = vld_r;
  assign o_item = item_r;

endmodule

// File: hw/rtl/csc_twist_cell.sv
module csc_twist_cell
  import csc_pkg::*;
#(
  parameter int unsigned POS = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      i_vld,
  input  csc_item_t i_item,
  output logic      o_vld,
  output csc_item_t o_item
);

  localparam logic [IDX_W-1:0] WEIGHT = IDX_W'(TW_WEIGHT[POS]);

  logic          vld_r;
  csc_item_t     item_r;
  csc_item_t     item_nxt;
  logic [TW_W-1:0] digit;
  logic [2:0]    sum;

  always_comb begin
    item_nxt = i_item;
    digit    = '0;
    if (i_item.acc >= WEIGHT) begin
      digit = digit + TW_W'(1);
    end
    if (i_item.acc >= IDX_W'(2 * TW_WEIGHT[POS])) begin
      digit = digit + TW_W'(1);
    end
    sum = 3'(i_item.tsum) + 3'(digit);
    unique case (i_item.op)
      OP_ENCODE: begin
        item_nxt.acc = i_item.acc + IDX_W'(i_item.twist_word[TW_W*POS +: TW_W]) * WEIGHT;
      end
      OP_DECODE: begin
        item_nxt.acc = i_item.acc - IDX_W'(digit) * WEIGHT;
        item_nxt.twist_acc[TW_W*POS +: TW_W] = digit;
        // keep the running sum mod 3
        item_nxt.tsum = (sum >= 3'd3) ? 2'(sum - 3'd3) : 2'(sum);
      end
      default: item_nxt = i_item;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign o_vld  = vld_r;
  assign o_item = item_r;

endmodule

// File: hw/rtl/corner_state_coordinate_codec_top.sv
// Corner state coordinate codec. Encode (in_tuser = 0) ranks the eight-element
// permutation by its factorial digits and appends the base-3 value of twists 0..6;
// decode (in_tuser = 1) splits the index back into the permutation and seven twists
// and forces the eighth twist so the twist sum is 0 mod 3. A row of fifteen
// registered cells, eight for the permutation digits and seven for the twist
// digits, peels or accumulates one digit each, followed by a result register:
// one item per cycle is accepted while out_tready stays high. The whole chain
// holds while a finished result waits on out_tready. out_tuser flags invalid
// input.
`include "corner_state_coordinate_codec_top_defines.svh"

module corner_state_coordinate_codec_top
  import csc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // perm_word[23:0], twist_word[39:24], state_index[66:40], zero fill
  input  logic [71:0] in_tdata,
  // opcode
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // index_out[26:0], perm_out[50:27], twist_out[66:51], zero fill
  output logic [71:0] out_tdata,
  // bad_input
  output logic        out_tuser
);

  localparam int unsigned IDX_LO = PERM_W + TWIST_W;

  logic              adv;
  logic [CELLS:0]    stage_vld;
  csc_item_t         stage_item [CELLS+1];
  logic [IDX_W-1:0]  in_index;

  logic              out_vld_r;
  csc_result_t       out_r;
  csc_result_t       out_nxt;
  csc_item_t         tail;
  logic [ELEMS-1:0]  seen;
  logic              twist3;
  logic [TW_W-1:0]   force_tw;

  // advance whenever the result register is free or being emptied
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign in_index  = in_tdata[IDX_LO +: IDX_W];

  always_comb begin
    stage_item[0]            = '0;
    stage_item[0].op         = csc_op_t'(in_tuser);
    stage_item[0].oor        = in_index >= IDX_W'(STATE_SPACE);
    stage_item[0].perm_word  = in_tdata[PERM_W-1:0];
    stage_item[0].twist_word = in_tdata[PERM_W +: TWIST_W];
    stage_item[0].acc        = (csc_op_t'(in_tuser) == OP_DECODE) ? in_index : '0;
    for (int j = 0; j < ELEMS; j++) begin
      stage_item[0].avail[j] = ELEM_W'(j);
    end
  end
  assign stage_vld[0] = in_tvalid;

  for (genvar g = 0; g < ELEMS; g++) begin : g_perm
    csc_perm_cell #(.POS(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .i_vld  (stage_vld[g]),
      .i_item (stage_item[g]),
      .o_vld  (stage_vld[g+1]),
      .o_item (stage_item[g+1])
    );
  end

  for (genvar g = 0; g < TW_DIGITS; g++) begin : g_twist
    csc_twist_cell #(.POS(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .i_vld  (stage_vld[ELEMS+g]),
      .i_item (stage_item[ELEMS+g]),
      .o_vld  (stage_vld[ELEMS+g+1]),
      .o_item (stage_item[ELEMS+g+1])
    );
  end

  assign tail = stage_item[CELLS];

  always_comb begin
    seen   = '0;
    twist3 = 1'b0;
    for (int i = 0; i < ELEMS; i++) begin
      seen[tail.perm_word[ELEM_W*i +: ELEM_W]] = 1'b1;
      if (tail.twist_word[TW_W*i +: TW_W] == 2'd3) begin
        twist3 = 1'b1;
      end
    end
    force_tw = (tail.tsum == 2'd0) ? 2'd0 : 2'd3 - tail.tsum;
    out_nxt    = '0;
    out_nxt.op = tail.op;
    unique case (tail.op)
      OP_ENCODE: begin
        out_nxt.bad   = (seen != {ELEMS{1'b1}}) || twist3;
        out_nxt.index = out_nxt.bad ? '0 : tail.acc;
      end
      OP_DECODE: begin
        out_nxt.bad = tail.oor;
        if (!tail.oor) begin
          out_nxt.perm  = tail.perm_acc;
          out_nxt.twist = {force_tw, tail.twist_acc};
        end
      end
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= stage_vld[CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'b0, out_r.twist, out_r.perm, out_r.index};
  assign out_tuser  = out_r.bad;

  `CSC_ASSERT_NEXT(a_chain_hold, !adv, $stable(stage_vld[CELLS:1]))
  `CSC_ASSERT_SAME(a_enc_range,
    out_vld_r && (out_r.op == OP_ENCODE) && !out_r.bad,
    out_r.index < IDX_W'(STATE_SPACE))
  `CSC_ASSERT_SAME(a_enc_zero,
    out_vld_r && (out_r.op == OP_ENCODE),
    (out_r.perm == '0) && (out_r.twist == '0))
  `CSC_ASSERT_SAME(a_dec_bad,
    out_vld_r && (out_r.op == OP_DECODE) && out_r.bad,
    (out_r.perm == '0) && (out_r.twist == '0) && (out_r.index == '0))

endmodule

// File: tb/corner_state_coordinate_codec_top_tb.sv
`timescale 1ns / 1ps

module corner_state_coordinate_codec_top_tb
  import csc_pkg::*;
();

  localparam int unsigned DIRECTED_ITEMS  = 22;
  localparam int unsigned RANDOM_ITEMS    = 1500;
  localparam int unsigned IDLE_PCT        = 29;
  localparam int unsigned CALM_FIRST      = 800;
  localparam int unsigned CALM_LAST       = 1100;
  localparam int unsigned HOLD_OFF_AT     = 300;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES    = 24;
  localparam int unsigned STALL_LIMIT     = 2000;

  localparam logic [PERM_W-1:0] IDENT_PERM    = 24'o76543210;
  localparam logic [PERM_W-1:0] REVERSED_PERM = 24'o01234567;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [PERM_W-1:0]  perm;
    logic [TWIST_W-1:0] twist;
    logic               bad;
  } coord_t;

  typedef struct packed {
    csc_op_t            op;
    logic [PERM_W-1:0]  perm;
    logic [TWIST_W-1:0] twist;
    logic [IDX_W-1:0]   index;
    logic               typed;
    coord_t             want;
  } dir_row_t;

  localparam coord_t REJECT = '{'0, '0, '0, 1'b1};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tuser;

  coord_t      coord_q [$];
  int unsigned n_sent = 0;
  int unsigned n_done = 0;
  int unsigned n_err = 0;
  int unsigned stall_cnt = 0;
  bit          calm = 1'b0;
  bit          held_off = 1'b0;

  // typed-in rows carry their result; the rest go through convert_coord
  dir_row_t dir_rows [DIRECTED_ITEMS] = '{
    '{OP_ENCODE, IDENT_PERM, 16'h0000, 27'd0, 1'b1, '{27'd0, 24'd0, 16'd0, 1'b0}},
    '{OP_ENCODE, REVERSED_PERM, 16'h2AAA, 27'd0, 1'b1,
      '{27'd88179839, 24'd0, 16'd0, 1'b0}},
    '{OP_ENCODE, IDENT_PERM, 16'h8000, 27'd0, 1'b1, '{27'd0, 24'd0, 16'd0, 1'b0}},
    '{OP_ENCODE, IDENT_PERM, 16'hC000, 27'd0, 1'b1, REJECT},
    '{OP_ENCODE, IDENT_PERM, 16'h0003, 27'd0, 1'b1, REJECT},
    '{OP_ENCODE, 24'h000000, 16'h0000, 27'd0, 1'b1, REJECT},
    '{OP_ENCODE, 24'hFFFFFF, 16'hFFFF, 27'd0, 1'b1, REJECT},
    '{OP_ENCODE, 24'o76543211, 16'h0000, 27'd0, 1'b1, REJECT},
    '{OP_DECODE, 24'h000000, 16'h0000, 27'd0, 1'b1,
      '{27'd0, IDENT_PERM, 16'h0000, 1'b0}},
    '{OP_DECODE, 24'h000000, 16'h0000, 27'd88179839, 1'b1,
      '{27'd0, REVERSED_PERM, 16'h6AAA, 1'b0}},
    '{OP_DECODE, 24'h000000, 16'h0000, 27'd88179840, 1'b1, REJECT},
    '{OP_DECODE, 24'h000000, 16'h0000, 27'h7FFFFFF, 1'b1, REJECT},
    '{OP_DECODE, 24'h000000, 16'h0000, 27'd2186, 1'b1,
      '{27'd0, IDENT_PERM, 16'h6AAA, 1'b0}},
    '{OP_DECODE, 24'h000000, 16'h0000, 27'd1, 1'b1,
      '{27'd0, IDENT_PERM, 16'h9000, 1'b0}},
    '{OP_ENCODE, IDENT_PERM, 16'h0001, 27'd0, 1'b1, '{27'd729, 24'd0, 16'd0, 1'b0}},
    '{OP_ENCODE, IDENT_PERM, 16'h1000, 27'd0, 1'b1, '{27'd1, 24'd0, 16'd0, 1'b0}},
    '{OP_ENCODE, 24'o76543201, 16'h0000, 27'd0, 1'b0, '0},
    '{OP_ENCODE, 24'o35160274, 16'h1269, 27'd0, 1'b0, '0},
    '{OP_DECODE, 24'hFFFFFF, 16'hFFFF, 27'd12345678, 1'b0, '0},
    '{OP_DECODE, 24'h000000, 16'h0000, 27'd45678901, 1'b0, '0},
    '{OP_ENCODE, IDENT_PERM, 16'h0000, 27'h7FFFFFF, 1'b1,
      '{27'd0, 24'd0, 16'd0, 1'b0}},
    '{OP_DECODE, 24'h000000, 16'h0000, 27'd88177652, 1'b0, '0}
  };

  corner_state_coordinate_codec_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  function automatic coord_t convert_coord(csc_op_t op, logic [PERM_W-1:0] pw,
                                           logic [TWIST_W-1:0] tw, logic [IDX_W-1:0] idx);
    coord_t      r;
    logic [7:0]  seen;
    logic [2:0]  pool [8];
    int unsigned prank;
    int unsigned trank;
    int unsigned less;
    int unsigned d;
    int unsigned sum;
    int unsigned t;
    r = '0;
    prank = 0;
    trank = 0;
    sum = 0;
    if (op == OP_ENCODE) begin
      seen = '0;
      for (int i = 0; i < 8; i++) begin
        seen[pw[3*i +: 3]] = 1'b1;
        if (tw[2*i +: 2] == 2'd3) r.bad = 1'b1;
      end
      if (seen != 8'hFF) r.bad = 1'b1;
      for (int i = 0; i < 8; i++) begin
        less = 0;
        for (int j = i + 1; j < 8; j++)
          if (pw[3*j +: 3] < pw[3*i +: 3]) less++;
        prank += less * FACT[7-i];
      end
      // twist 0 is the most significant base-3 digit; twist 7 stays out
      for (int i = 0; i < 7; i++)
        trank = trank * 3 + tw[2*i +: 2];
      if (!r.bad) r.index = IDX_W'(prank * TWIST_SPACE + trank);
    end else if (idx >= STATE_SPACE) begin
      r.bad = 1'b1;
    end else begin
      prank = idx / TWIST_SPACE;
      trank = idx % TWIST_SPACE;
      for (int i = 0; i < 8; i++) pool[i] = 3'(i);
      for (int i = 0; i < 8; i++) begin
        d = prank / FACT[7-i];
        prank = prank % FACT[7-i];
        if (d > 7 - i) d = 7 - i;
        r.perm[3*i +: 3] = pool[d];
        for (int j = d; j < 7 - i; j++) pool[j] = pool[j+1];
      end
      for (int i = 6; i >= 0; i--) begin
        t = trank % 3;
        trank = trank / 3;
        sum += t;
        r.twist[2*i +: 2] = 2'(t);
      end
      // force the total twist to 0 mod 3
      r.twist[15:14] = 2'((3 - sum % 3) % 3);
    end
    return r;
  endfunction

  initial begin : feed
    csc_op_t           op;
    logic [PERM_W-1:0] pw;
    logic [TWIST_W-1:0] tw;
    logic [IDX_W-1:0]  idx;
    logic [2:0]        pool [8];
    logic [2:0]        swap;
    int unsigned       pick;
    int unsigned       kind;
    int unsigned       slot;
    coord_t            want;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= 1'b0;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int unsigned k = 0; k < DIRECTED_ITEMS + RANDOM_ITEMS; k++) begin
      calm = (k >= CALM_FIRST && k < CALM_LAST);
      if (k < DIRECTED_ITEMS) begin
        op  = dir_rows[k].op;
        pw  = dir_rows[k].perm;
        tw  = dir_rows[k].twist;
        idx = dir_rows[k].index;
      end else begin
        // unused fields carry random garbage
        pw   = PERM_W'($urandom());
        tw   = TWIST_W'($urandom());
        idx  = IDX_W'($urandom());
        kind = $urandom_range(0, 99);
        op   = (kind < 56) ? OP_ENCODE : OP_DECODE;
        if (kind < 56) begin
          for (int i = 0; i < 8; i++) pool[i] = 3'(i);
          for (int i = 7; i > 0; i--) begin
            pick = $urandom_range(0, i);
            swap = pool[i];
            pool[i] = pool[pick];
            pool[pick] = swap;
          end
          for (int i = 0; i < 8; i++) begin
            pw[3*i +: 3] = pool[i];
            tw[2*i +: 2] = 2'($urandom_range(0, 2));
          end
          slot = $urandom_range(0, 7);
          // break a few: duplicate an element or plant a twist of three
          if (kind >= 48) pw[3*slot +: 3] = pw[3*((slot + 1) % 8) +: 3];
          else if (kind >= 40) tw[2*slot +: 2] = 2'd3;
        end else if (kind < 60) begin
          idx = IDX_W'(STATE_SPACE - 1 - $urandom_range(0, 5000));
        end else if (kind < 92) begin
          idx = IDX_W'($urandom_range(0, STATE_SPACE - 1));
        end else begin
          op = csc_op_t'($urandom_range(0, 1));
        end
      end
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser  <= op;
      in_tdata  <= {5'd0, idx, tw, pw};
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      if (k < DIRECTED_ITEMS && dir_rows[k].typed) want = dir_rows[k].want;
      else want = convert_coord(op, pw, tw, idx);
      coord_q = {coord_q, want};
      n_sent++;
    end
    in_tvalid <= 1'b0;
    while (n_done < n_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_err == 0 && coord_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : drain
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held_off && n_sent >= HOLD_OFF_AT) begin
        // hold off long enough for the chain to fill and stall the input
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check
    coord_t want;
    coord_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.index = out_tdata[26:0];
        got.perm  = out_tdata[50:27];
        got.twist = out_tdata[66:51];
        got.bad   = out_tuser;
        if (coord_q.size() == 0) begin
          $error("unexpected result transfer: index_out %0d", got.index);
          n_err++;
        end else begin
          want = coord_q.pop_front();
          if (got.index !== want.index) begin
            $error("index_out: expected %0d, got %0d", want.index, got.index);
            n_err++;
          end
          if (got.perm !== want.perm) begin
            $error("perm_out: expected %06h, got %06h", want.perm, got.perm);
            n_err++;
          end
          if (got.twist !== want.twist) begin
            $error("twist_out: expected %04h, got %04h", want.twist, got.twist);
            n_err++;
          end
          if (got.bad !== want.bad) begin
            $error("bad_input: expected %0b, got %0b", want.bad, got.bad);
            n_err++;
          end
          n_done++;
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/csc_pkg.sv
hw/rtl/csc_perm_cell.sv
hw/rtl/csc_twist_cell.sv
hw/rtl/corner_state_coordinate_codec_top.sv
tb/corner_state_coordinate_codec_top_tb.sv
